/* rtl/core/wget_pkg.sv */
// wget_pkg: shared constants, types and codes for the weighted graph edge table
// no dependencies; used by the interfaces and every module of the block
`default_nettype none

package wget_pkg;

    // graph geometry
    localparam int NUM_VERTICES = 16;
    localparam int VTX_W        = $clog2(NUM_VERTICES);
    localparam int ADDR_W       = 2 * VTX_W;
    localparam int NUM_EDGES    = NUM_VERTICES * NUM_VERTICES;

    // field widths
    localparam int ACT_W = 2;
    localparam int WGT_W = 32;
    localparam int CNT_W = $clog2(NUM_EDGES + 1);
    localparam int DEG_W = $clog2(NUM_VERTICES + 1);

    // action codes
    localparam logic [ACT_W-1:0] ACT_SET   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEL   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FIRST = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NEXT  = 2'd3;

    typedef logic [VTX_W-1:0]        t_vertex;
    typedef logic signed [WGT_W-1:0] t_weight;
    typedef logic [CNT_W-1:0]        t_count;
    typedef logic [DEG_W-1:0]        t_degree;
    typedef logic [NUM_VERTICES-1:0] t_row;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take_item;
        logic exec;
        logic load_out;
    } t_cmd;

endpackage

`default_nettype wire

/* rtl/core/wget_intf.sv */
// wget_in_if / wget_out_if: valid-ready channels for items and results
// depends on wget_pkg
`default_nettype none

interface wget_in_if;
    logic                        valid;
    logic                        ready;
    logic [wget_pkg::ACT_W-1:0]  action;
    wget_pkg::t_vertex           from_vertex;
    wget_pkg::t_vertex           to_vertex;
    wget_pkg::t_weight           edge_weight;

    modport source (output valid, action, from_vertex, to_vertex, edge_weight, input ready);
    modport sink   (input valid, action, from_vertex, to_vertex, edge_weight, output ready);
endinterface

interface wget_out_if;
    logic              valid;
    logic              ready;
    logic              found;
    wget_pkg::t_vertex neighbor;
    wget_pkg::t_weight neighbor_weight;
    wget_pkg::t_count  edge_total;
    wget_pkg::t_degree target_in_degree;

    modport source (output valid, found, neighbor, neighbor_weight, edge_total,
                    target_in_degree, input ready);
    modport sink   (input valid, found, neighbor, neighbor_weight, edge_total,
                    target_in_degree, output ready);
endinterface

`default_nettype wire

/* rtl/core/weighted_graph_edge_table_core.sv */
// weighted_graph_edge_table_core: top level of the directed weighted graph edge table
// depends on wget_pkg, wget_intf, wget_ctrl and wget_dp
//
//   channel    dir  transfer when         payload
//   i_item     in   valid && ready        action, from_vertex, to_vertex, edge_weight
//   o_result   out  valid && ready        found, neighbor, neighbor_weight,
//                                         edge_total, target_in_degree
//
// each item is latched when taken; the execute state updates the bitmap, counts and
// weight memory, and the load state loads the result register from the registered
// weight-memory read; a new item is taken in the load state while the result
// register is free, as the last result loads; a stalled result holds the next load
// synchronous active-low reset clears the edge bitmap, in-degrees and edge count;
// the weight memory is not cleared and needs no clearing pass
`default_nettype none

module weighted_graph_edge_table_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wget_in_if.sink    i_item,
    wget_out_if.source o_result
);

    wget_pkg::t_cmd cmd;

    wget_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .o_cmd       (cmd)
    );

    wget_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_action           (i_item.action),
        .i_from_vertex      (i_item.from_vertex),
        .i_to_vertex        (i_item.to_vertex),
        .i_edge_weight      (i_item.edge_weight),
        .o_found            (o_result.found),
        .o_neighbor         (o_result.neighbor),
        .o_neighbor_weight  (o_result.neighbor_weight),
        .o_edge_total       (o_result.edge_total),
        .o_target_in_degree (o_result.target_in_degree)
    );

endmodule

`default_nettype wire

/* rtl/core/wget_ctrl.sv */
// wget_ctrl: sequencer for accept, execute and result load, owns the handshakes
// depends on wget_pkg
`default_nettype none

module wget_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output      logic           o_in_ready,
    input  wire logic           i_out_ready,
    output      logic           o_out_valid,
    output      wget_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic       take;

    // result register can take a new value
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_LOAD) && out_free);
    assign take       = i_in_valid && o_in_ready;

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd.take_item = take;
        o_cmd.exec      = 1'b0;
        o_cmd.load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = take ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* rtl/core/wget_dp.sv */
// wget_dp: edge bitmap, in-degree counters, edge counter, weight memory, result register
// depends on wget_pkg
`default_nettype none

module wget_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire wget_pkg::t_cmd             i_cmd,
    input  wire logic [wget_pkg::ACT_W-1:0] i_action,
    input  wire wget_pkg::t_vertex          i_from_vertex,
    input  wire wget_pkg::t_vertex          i_to_vertex,
    input  wire wget_pkg::t_weight          i_edge_weight,
    output      logic                       o_found,
    output      wget_pkg::t_vertex          o_neighbor,
    output      wget_pkg::t_weight          o_neighbor_weight,
    output      wget_pkg::t_count           o_edge_total,
    output      wget_pkg::t_degree          o_target_in_degree
);

    // latched item
    logic [wget_pkg::ACT_W-1:0] r_act;
    wget_pkg::t_vertex          r_src;
    wget_pkg::t_vertex          r_dst;
    wget_pkg::t_weight          r_w;

    // graph state
    wget_pkg::t_row    r_present [wget_pkg::NUM_VERTICES];
    wget_pkg::t_degree r_indeg   [wget_pkg::NUM_VERTICES];
    wget_pkg::t_count  r_edges;
    wget_pkg::t_weight r_wmem    [wget_pkg::NUM_EDGES];
    wget_pkg::t_weight r_rdata;

    // per-item results waiting for the weight read
    logic              r_found;
    wget_pkg::t_vertex r_nb;
    wget_pkg::t_degree r_deg;

    // result register
    logic              r_o_found;
    wget_pkg::t_vertex r_o_nb;
    wget_pkg::t_weight r_o_w;
    wget_pkg::t_count  r_o_edges;
    wget_pkg::t_degree r_o_deg;

    wget_pkg::t_row    row;
    wget_pkg::t_row    cand;
    logic              hit;
    wget_pkg::t_vertex hit_idx;
    logic              cur_bit;
    logic              is_set, is_del, is_query;
    logic              add_edge, del_edge;
    wget_pkg::t_count  n_edges;
    wget_pkg::t_degree n_deg;
    logic [wget_pkg::ADDR_W-1:0] rd_addr;
    logic [wget_pkg::ADDR_W-1:0] wr_addr;

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_act <= i_action;
            r_src <= i_from_vertex;
            r_dst <= i_to_vertex;
            r_w   <= i_edge_weight;
        end
    end

    // decode and row scan
    assign row      = r_present[r_src];
    assign cur_bit  = row[r_dst];
    assign is_set   = (r_act == wget_pkg::ACT_SET);
    assign is_del   = (r_act == wget_pkg::ACT_DEL);
    assign is_query = (r_act == wget_pkg::ACT_FIRST) || (r_act == wget_pkg::ACT_NEXT);
    assign add_edge = is_set && !cur_bit;
    assign del_edge = is_del && cur_bit;

    // candidates: whole row for first, bits above the previous neighbor for next
    always_comb begin
        for (int i = 0; i < wget_pkg::NUM_VERTICES; i++) begin
            cand[i] = row[i] && ((r_act == wget_pkg::ACT_FIRST) ||
                                 (wget_pkg::VTX_W'(i) > r_dst));
        end
    end

    // lowest candidate wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = wget_pkg::NUM_VERTICES - 1; i >= 0; i--) begin
            if (cand[i]) begin
                hit     = 1'b1;
                hit_idx = wget_pkg::VTX_W'(i);
            end
        end
    end

    // counts after this item
    always_comb begin
        n_edges = r_edges;
        n_deg   = r_indeg[r_dst];
        if (add_edge) begin
            n_edges = r_edges + 1'b1;
            n_deg   = r_indeg[r_dst] + 1'b1;
        end else if (del_edge) begin
            n_edges = r_edges - 1'b1;
            n_deg   = r_indeg[r_dst] - 1'b1;
        end
    end

    // bitmap and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edges <= '0;
            for (int i = 0; i < wget_pkg::NUM_VERTICES; i++) begin
                r_present[i] <= '0;
                r_indeg[i]   <= '0;
            end
        end else if (i_cmd.exec) begin
            r_edges        <= n_edges;
            r_indeg[r_dst] <= n_deg;
            if (add_edge) begin
                r_present[r_src][r_dst] <= 1'b1;
            end else if (del_edge) begin
                r_present[r_src][r_dst] <= 1'b0;
            end
        end
    end

    // weight memory, one read per item and a write for each set
    assign rd_addr = {r_src, hit_idx};
    assign wr_addr = {r_src, r_dst};

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (is_set) begin
                r_wmem[wr_addr] <= r_w;
            end
            r_rdata <= r_wmem[rd_addr];
        end
    end

    // per-item results
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_found <= (is_query && hit) || del_edge;
            r_nb    <= (is_query && hit) ? hit_idx : '0;
            r_deg   <= n_deg;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_found <= r_found;
            r_o_nb    <= r_nb;
            r_o_w     <= (r_found && is_query) ? r_rdata : '0;
            r_o_edges <= r_edges;
            r_o_deg   <= r_deg;
        end
    end

    assign o_found            = r_o_found;
    assign o_neighbor         = r_o_nb;
    assign o_neighbor_weight  = r_o_w;
    assign o_edge_total       = r_o_edges;
    assign o_target_in_degree = r_o_deg;

endmodule

`default_nettype wire
